[hdl/scte_pkg.sv]
// ----------------------------------------------------------------------------
// scte_pkg
// Shared types and constants for the SEI caption triplet extractor.
// ----------------------------------------------------------------------------
package scte_pkg;

  // Fixed field and counter widths
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned TRIP_W   = 24;
  localparam int unsigned MAX_TRIPLETS = 31;

  // Saturation ceiling of the type and size sums
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Stream constants
  localparam logic [7:0] EPB_BYTE     = 8'h03;
  localparam logic [7:0] EXT_BYTE     = 8'hFF;
  localparam logic [4:0] CC_CNT_MASK  = 5'h1F;

  // SEI / A/53 constants
  localparam logic [SUM_W-1:0] SEI_TYPE_CC   = 17'd4;
  localparam logic [SUM_W-1:0] CC_MIN_SIZE   = 17'd10;
  localparam logic [SUM_W-1:0] CC_FLAGS_OFS  = 17'd8;
  localparam logic [SUM_W-1:0] CC_DATA_OFS   = 17'd10;
  localparam logic [SUM_W-1:0] CC_SIG_BYTES  = 17'd8;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] nal_byte;
    logic       end_of_unit;
  } scte_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [TRIP_W-1:0] triplet;
    logic [CNT_W-1:0]  triplet_total;
    logic              run_last;
  } scte_out_t;

  // Expected header bytes of the user data payload, offsets 0..7:
  // country code, provider code, GA94 identifier, user data type
  function automatic logic [7:0] sig_byte(input logic [2:0] ofs);
    logic [7:0] val;
    unique case (ofs)
      3'd0:    val = 8'hB5;
      3'd1:    val = 8'h00;
      3'd2:    val = 8'h31;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h41;
      3'd5:    val = 8'h39;
      3'd6:    val = 8'h34;
      default: val = 8'h03;
    endcase
    return val;
  endfunction

  // Saturating add of one field byte (0xFF counts as 255)
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [7:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-7){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

[hdl/sei_caption_triplet_extractor.sv]
// ----------------------------------------------------------------------------
// sei_caption_triplet_extractor
// Parses one SEI NAL unit per run of bytes and emits its A/53 cc triplets.
// ----------------------------------------------------------------------------
// Throughput: a byte per cycle in, a result per cycle out, unless stalled.
// Output path: hand-off slot, then drain state, then registered read port.
// Triplets are kept in a two-bank memory, so a unit is parsed while the
// previous one drains; byte input stalls only when a unit ends while the
// one before it is still draining (up to 31 results).
// Reset clears parser state and job/drain/valid flags, not memory or data.
module sei_caption_triplet_extractor (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  scte_pkg::scte_in_t  byte_item,
  output logic                result_valid,
  input  logic                result_ready,
  output scte_pkg::scte_out_t result_item
);
  import scte_pkg::*;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_TYPE   = 6'b000010,
    PH_SIZE   = 6'b000100,
    PH_CHECK  = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_IDLE   = 6'b100000
  } phase_t;

  // Parser state
  logic [1:0]       zero_run,   zero_run_next;
  phase_t           phase,      phase_next;
  logic [SUM_W-1:0] type_sum,   type_sum_next;
  logic [SUM_W-1:0] size_sum,   size_sum_next;
  logic [SUM_W-1:0] offset,     offset_next;
  logic [CNT_W-1:0] cand_count, cand_count_next;
  logic             cand_valid, cand_valid_next;
  logic [CNT_W-1:0] trip_idx,   trip_idx_next;
  logic [1:0]       trip_byte,  trip_byte_next;
  logic [15:0]      trip_sh,    trip_sh_next;
  logic             wbank,      wbank_next;

  // Hand-off and drain state
  logic             job_pending;
  logic             job_bank;
  logic [CNT_W-1:0] job_count;
  logic             drn_active;
  logic             drn_bank;
  logic [CNT_W-1:0] drn_idx;
  logic [CNT_W-1:0] drn_count;

  // Triplet memory: two banks of 2**CNT_W entries, MAX_TRIPLETS used in each
  logic [TRIP_W-1:0] mem [0:(2**(CNT_W+1))-1];
  logic [TRIP_W-1:0] res_trip;
  logic [CNT_W-1:0]  res_total;
  logic              res_last;

  logic               accept;
  logic [7:0]         b;
  logic               drop;
  logic               chk_fail;
  phase_t             ph_after;
  logic [SUM_W-1:0]   acc;
  logic [7:0]         need_size;
  logic [CNT_W-1:0]   cc_cnt;
  logic               wr_en;
  logic [CNT_W:0]     wr_addr;
  logic [TRIP_W-1:0]  wr_data;
  logic               new_job;
  logic [CNT_W-1:0]   new_count;
  logic               out_load;
  logic               drn_last;
  logic               take;

  // The hand-off slot frees up in the cycle the drainer takes it
  assign accept     = byte_valid && byte_ready;
  assign byte_ready = !job_pending || take;
  assign b          = byte_item.nal_byte;
  assign drop       = (b == EPB_BYTE) && (zero_run == 2'd2);
  assign cc_cnt     = b[4:0] & CC_CNT_MASK;
  assign need_size  = 8'd10 + {2'b00, cc_cnt, 1'b0} + {3'b000, cc_cnt};

  // Per-byte parse step
  always_comb begin
    zero_run_next   = zero_run;
    phase_next      = phase;
    type_sum_next   = type_sum;
    size_sum_next   = size_sum;
    offset_next     = offset;
    cand_count_next = cand_count;
    cand_valid_next = cand_valid;
    trip_idx_next   = trip_idx;
    trip_byte_next  = trip_byte;
    trip_sh_next    = trip_sh;
    wbank_next      = wbank;
    wr_en           = 1'b0;
    wr_addr         = {wbank, trip_idx};
    wr_data         = {trip_sh, b};
    chk_fail        = 1'b0;
    ph_after        = phase;
    acc             = '0;
    new_job         = 1'b0;
    new_count       = '0;
    if (accept) begin
      if (drop) begin
        zero_run_next = 2'd0;
      end else begin
        zero_run_next = (b != 8'h00) ? 2'd0 :
                        (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
        unique case (phase)
          PH_HEADER: begin
            phase_next    = PH_TYPE;
            type_sum_next = '0;
          end
          PH_TYPE: begin
            type_sum_next = sat_add(type_sum, b);
            if (b != EXT_BYTE) begin
              phase_next    = PH_SIZE;
              size_sum_next = '0;
            end
          end
          PH_SIZE: begin
            acc           = sat_add(size_sum, b);
            size_sum_next = acc;
            if (b != EXT_BYTE) begin
              offset_next = '0;
              priority if (acc == SUM_MAX) begin
                phase_next = PH_IDLE;
              end else if (acc == '0) begin
                phase_next    = PH_TYPE;
                type_sum_next = '0;
              end else if (type_sum == SEI_TYPE_CC && acc >= CC_MIN_SIZE) begin
                phase_next = PH_CHECK;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
          PH_CHECK, PH_SKIP: begin
            if (phase == PH_CHECK) begin
              priority if (offset < CC_SIG_BYTES) begin
                chk_fail = (b != sig_byte(offset[2:0]));
              end else if (offset == CC_FLAGS_OFS) begin
                chk_fail = !(b[6] && cc_cnt != '0 &&
                             size_sum >= {{(SUM_W-8){1'b0}}, need_size});
                if (!chk_fail) begin
                  cand_count_next = cc_cnt;
                  trip_idx_next   = '0;
                  trip_byte_next  = 2'd0;
                end
              end else if (offset >= CC_DATA_OFS && trip_idx < cand_count) begin
                trip_sh_next = {trip_sh[7:0], b};
                if (trip_byte == 2'd2) begin
                  wr_en          = 1'b1;
                  trip_idx_next  = trip_idx + 1'b1;
                  trip_byte_next = 2'd0;
                end else begin
                  trip_byte_next = trip_byte + 2'd1;
                end
              end else begin
                chk_fail = 1'b0;
              end
            end
            ph_after    = chk_fail ? PH_SKIP : phase;
            offset_next = offset + 1'b1;
            if (offset_next >= size_sum) begin
              if (ph_after == PH_CHECK) begin
                cand_valid_next = 1'b1;
                phase_next      = PH_IDLE;
              end else begin
                phase_next    = PH_TYPE;
                type_sum_next = '0;
              end
            end else begin
              phase_next = ph_after;
            end
          end
          PH_IDLE: begin
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      // End of unit: hand the bank to the drainer and restart
      if (byte_item.end_of_unit) begin
        new_job         = 1'b1;
        new_count       = cand_valid_next ? cand_count_next : '0;
        wbank_next      = !wbank;
        zero_run_next   = 2'd0;
        phase_next      = PH_HEADER;
        type_sum_next   = '0;
        size_sum_next   = '0;
        offset_next     = '0;
        cand_count_next = '0;
        cand_valid_next = 1'b0;
        trip_idx_next   = '0;
        trip_byte_next  = 2'd0;
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run   <= 2'd0;
      phase      <= PH_HEADER;
      type_sum   <= '0;
      size_sum   <= '0;
      offset     <= '0;
      cand_count <= '0;
      cand_valid <= 1'b0;
      trip_idx   <= '0;
      trip_byte  <= 2'd0;
      wbank      <= 1'b0;
    end else begin
      zero_run   <= zero_run_next;
      phase      <= phase_next;
      type_sum   <= type_sum_next;
      size_sum   <= size_sum_next;
      offset     <= offset_next;
      cand_count <= cand_count_next;
      cand_valid <= cand_valid_next;
      trip_idx   <= trip_idx_next;
      trip_byte  <= trip_byte_next;
      wbank      <= wbank_next;
    end
  end

  always_ff @(posedge clk) begin
    trip_sh <= trip_sh_next;
  end

  // Drain control
  assign out_load = drn_active && (!result_valid || result_ready);
  assign drn_last = (drn_count == '0) || (CNT_W'(drn_idx + 1'b1) == drn_count);
  assign take     = job_pending && (!drn_active || (out_load && drn_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      job_pending  <= 1'b0;
      drn_active   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      job_pending <= (job_pending && !take) || new_job;
      if (take) begin
        drn_active <= 1'b1;
      end else if (out_load && drn_last) begin
        drn_active <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_job) begin
      job_bank  <= wbank;
      job_count <= new_count;
    end
    if (take) begin
      drn_bank  <= job_bank;
      drn_count <= job_count;
      drn_idx   <= '0;
    end else if (out_load) begin
      drn_idx <= drn_idx + 1'b1;
    end
  end

  // Triplet memory, write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (out_load) begin
      res_trip  <= (drn_count == '0) ? '0 : mem[{drn_bank, drn_idx}];
      res_total <= drn_count;
      res_last  <= drn_last;
    end
  end

  assign result_item.triplet       = res_trip;
  assign result_item.triplet_total = res_total;
  assign result_item.run_last      = res_last;

  // Checks
  a_bank_disjoint: assert property (@(posedge clk) disable iff (rst)
    wr_en && drn_active |-> wr_addr[CNT_W] != drn_bank)
    else $error("triplet write hits the bank being drained");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.triplet_total == '0 |-> result_item.run_last)
    else $error("empty result not marked last");

  a_cand_idle: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> phase == PH_IDLE)
    else $error("complete candidate while still parsing");

  a_trip_bound: assert property (@(posedge clk) disable iff (rst)
    trip_idx <= cand_count)
    else $error("triplet index past candidate count");

  a_pending_stalls: assert property (@(posedge clk) disable iff (rst)
    job_pending && drn_active && !(out_load && drn_last) |=> job_pending)
    else $error("pending unit dropped while drain busy");

endmodule
